>>> rtl/core/kfpu_pkg.sv
package kfpu_pkg;

  localparam int STATE_SIZE_DEF = 2;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int VAL_W          = 32;
  localparam int COEF_W         = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;
  localparam int PC_W           = 5;
  localparam int QUO_W          = 33;

  localparam logic [63:0] TRANS_RESET  = 64'h0100_0000_0000_0100;
  localparam logic [63:0] PNOISE_RESET = 64'h0100_0000_0000_0100;
  localparam logic [31:0] HROW_RESET   = 32'h0100_0000;
  localparam logic [15:0] RNOISE_RESET = 16'h0100;

  typedef enum logic [1:0] {
    REG_TRANS,
    REG_PNOISE,
    REG_HROW,
    REG_RNOISE
  } reg_e;

  // Operand registers of the datapath: state, covariance and scratch.
  typedef enum logic [3:0] {
    V_X0, V_X1, V_P00, V_P01, V_P10, V_P11,
    V_T0, V_T1, V_T2, V_T3, V_T4, V_T5, V_T6, V_T7
  } vsel_e;

  typedef enum logic [3:0] {
    B_F00, B_F01, B_F10, B_F11, B_H0, B_H1, B_T4, B_T6, B_T7
  } bsel_e;

  typedef enum logic [2:0] {
    T_NONE, T_QADD, T_RADD, T_ZSUB, T_DADD, T_DSUB
  } term_e;

  typedef enum logic [2:0] {
    I_DOT, I_COPY, I_CHK, I_DIV, I_END
  } ins_e;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MAC1, S_WAIT, S_WB, S_DIVW, S_FIN
  } state_e;

  // The innovation variance always lands in this scratch register.
  localparam vsel_e V_S = V_T5;

  localparam logic [PC_W-1:0] PRED_BASE = 5'd0;
  localparam logic [PC_W-1:0] UPD_BASE  = 5'd12;

  typedef struct packed {
    ins_e        kind;
    vsel_e       a0;
    bsel_e       b0;
    vsel_e       a1;
    bsel_e       b1;
    logic        two;
    logic        frac;
    term_e       term;
    logic [1:0]  qsel;
    vsel_e       dst;
    logic        hi;
  } ins_t;

  typedef struct packed {
    logic       load;
    logic       mac;
    logic       clr;
    vsel_e      a;
    bsel_e      b;
    logic       wb;
    logic       copy;
    logic       frac;
    term_e      term;
    logic [1:0] qsel;
    vsel_e      dst;
    logic       hi;
    logic       div_start;
    logic       div_wb;
    logic       publish;
    logic       sing;
  } cmd_t;

  typedef struct packed {
    logic s_zero;
    logic div_done;
  } sts_t;

  function automatic ins_t dot2(input vsel_e a0, input bsel_e b0, input vsel_e a1,
                                input bsel_e b1, input term_e term, input logic [1:0] qsel,
                                input vsel_e dst, input logic hi);
    ins_t i;
    i.kind = I_DOT;
    i.a0   = a0;
    i.b0   = b0;
    i.a1   = a1;
    i.b1   = b1;
    i.two  = 1'b1;
    i.frac = 1'b0;
    i.term = term;
    i.qsel = qsel;
    i.dst  = dst;
    i.hi   = hi;
    return i;
  endfunction

  function automatic ins_t dot1(input vsel_e a0, input bsel_e b0, input term_e term,
                                input vsel_e dst, input logic hi);
    ins_t i;
    i = dot2(a0, b0, a0, b0, term, 2'd0, dst, hi);
    i.two  = 1'b0;
    i.frac = 1'b1;
    return i;
  endfunction

  function automatic ins_t ins_op(input ins_e kind, input vsel_e a0, input vsel_e dst,
                                  input logic hi);
    ins_t i;
    i = dot2(a0, B_F00, a0, B_F00, T_NONE, 2'd0, dst, hi);
    i.kind = kind;
    return i;
  endfunction

  // Sequencer program: predict from PRED_BASE, update from UPD_BASE.
  function automatic ins_t prog(input logic [PC_W-1:0] pc);
    ins_t i;
    i = ins_op(I_END, V_X0, V_X0, 1'b0);
    unique case (pc)
      5'd0:  i = dot2(V_X0, B_F00, V_X1, B_F01, T_NONE, 2'd0, V_T4, 1'b0);
      5'd1:  i = dot2(V_X0, B_F10, V_X1, B_F11, T_NONE, 2'd0, V_X1, 1'b1);
      5'd2:  i = ins_op(I_COPY, V_T4, V_X0, 1'b0);
      5'd3:  i = dot2(V_P00, B_F00, V_P10, B_F01, T_NONE, 2'd0, V_T0, 1'b0);
      5'd4:  i = dot2(V_P01, B_F00, V_P11, B_F01, T_NONE, 2'd0, V_T1, 1'b1);
      5'd5:  i = dot2(V_P00, B_F10, V_P10, B_F11, T_NONE, 2'd0, V_T2, 1'b1);
      5'd6:  i = dot2(V_P01, B_F10, V_P11, B_F11, T_NONE, 2'd0, V_T3, 1'b1);
      5'd7:  i = dot2(V_T0, B_F00, V_T1, B_F01, T_QADD, 2'd0, V_P00, 1'b0);
      5'd8:  i = dot2(V_T0, B_F10, V_T1, B_F11, T_QADD, 2'd1, V_P01, 1'b1);
      5'd9:  i = dot2(V_T2, B_F00, V_T3, B_F01, T_QADD, 2'd2, V_P10, 1'b1);
      5'd10: i = dot2(V_T2, B_F10, V_T3, B_F11, T_QADD, 2'd3, V_P11, 1'b1);
      5'd11: i = ins_op(I_END, V_X0, V_X0, 1'b0);
      5'd12: i = dot2(V_X0, B_H0, V_X1, B_H1, T_ZSUB, 2'd0, V_T4, 1'b0);
      5'd13: i = dot2(V_P00, B_H0, V_P01, B_H1, T_NONE, 2'd0, V_T0, 1'b0);
      5'd14: i = dot2(V_P10, B_H0, V_P11, B_H1, T_NONE, 2'd0, V_T1, 1'b1);
      5'd15: i = dot2(V_T0, B_H0, V_T1, B_H1, T_RADD, 2'd0, V_S, 1'b0);
      5'd16: i = ins_op(I_CHK, V_S, V_S, 1'b0);
      5'd17: i = ins_op(I_DIV, V_T0, V_T2, 1'b0);
      5'd18: i = ins_op(I_DIV, V_T1, V_T3, 1'b1);
      5'd19: i = dot2(V_P00, B_H0, V_P10, B_H1, T_NONE, 2'd0, V_T6, 1'b0);
      5'd20: i = dot2(V_P01, B_H0, V_P11, B_H1, T_NONE, 2'd0, V_T7, 1'b1);
      5'd21: i = dot1(V_T2, B_T4, T_DADD, V_X0, 1'b0);
      5'd22: i = dot1(V_T3, B_T4, T_DADD, V_X1, 1'b1);
      5'd23: i = dot1(V_T2, B_T6, T_DSUB, V_P00, 1'b0);
      5'd24: i = dot1(V_T2, B_T7, T_DSUB, V_P01, 1'b1);
      5'd25: i = dot1(V_T3, B_T6, T_DSUB, V_P10, 1'b1);
      5'd26: i = dot1(V_T3, B_T7, T_DSUB, V_P11, 1'b1);
      default: i = ins_op(I_END, V_X0, V_X0, 1'b0);
    endcase
    return i;
  endfunction

endpackage

>>> rtl/core/kfpu_div.sv
module kfpu_div #(
  parameter int DW = kfpu_pkg::FRAC_BITS_DEF + 33,
  parameter int QW = kfpu_pkg::QUO_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [31:0]   divisor_i,
  output logic          done_o,
  output logic          ovf_o,
  output logic [QW-1:0] quo_o
);

  localparam int CW = $clog2(QW + 1);

  logic [31:0]   rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [31:0]   dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d, ovf_q, ovf_d;
  logic [DW-1:0] hi_part;
  logic [32:0]   trial;
  logic [32:0]   diff;

  assign hi_part = dividend_i >> QW;
  assign trial   = {rem_q, quo_q[QW-1]};
  assign diff    = trial - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    ovf_d  = ovf_q;
    if (start_i) begin
      dvs_d = divisor_i;
      // A quotient of 2^QW or more is only ever clipped, so stop right away.
      if (hi_part >= DW'(divisor_i)) begin
        ovf_d  = 1'b1;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        ovf_d  = 1'b0;
        done_d = 1'b0;
        busy_d = 1'b1;
        rem_d  = 32'(hi_part);
        quo_d  = dividend_i[QW-1:0];
        cnt_d  = CW'(QW);
      end
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      ovf_q  <= ovf_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign quo_o  = quo_q;

endmodule

>>> rtl/core/kfpu_datapath.sv
module kfpu_datapath #(
  parameter int STATE_SIZE = kfpu_pkg::STATE_SIZE_DEF,
  parameter int FRAC_BITS  = kfpu_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kfpu_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [kfpu_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic signed [31:0]                measurement_i,
  input  kfpu_pkg::cmd_t                    cmd_i,
  output kfpu_pkg::sts_t                    sts_o,
  output logic signed [31:0]                est_first_o,
  output logic signed [31:0]                est_second_o,
  output logic signed [31:0]                cov_00_o,
  output logic signed [31:0]                cov_01_o,
  output logic signed [31:0]                cov_10_o,
  output logic signed [31:0]                cov_11_o,
  output logic                              singular_o,
  output logic                              saturated_o
);

  localparam int AW  = 66;
  localparam int QW  = kfpu_pkg::QUO_W;
  localparam int DW  = FRAC_BITS + QW;
  localparam int WID = FRAC_BITS - 8;

  logic [63:0] trans_q, pnoise_q;
  logic [31:0] hrow_q;
  logic [15:0] rnoise_q;

  logic signed [31:0] x0_q, x1_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [31:0] t0_q, t1_q, t2_q, t3_q, t4_q, t5_q, t6_q, t7_q;
  logic signed [31:0] z_q;
  logic               sat_q, div_neg_q, mac_q, clr_q;
  logic signed [63:0] prod_q;
  logic signed [AW-1:0] acc_q;

  logic signed [31:0] est_first_q, est_second_q, cov_00_q, cov_01_q, cov_10_q, cov_11_q;
  logic               sing_out_q, sat_out_q;

  function automatic logic signed [31:0] vget(
    input kfpu_pkg::vsel_e s,
    input logic signed [31:0] x0, input logic signed [31:0] x1,
    input logic signed [31:0] p00, input logic signed [31:0] p01,
    input logic signed [31:0] p10, input logic signed [31:0] p11,
    input logic signed [31:0] t0, input logic signed [31:0] t1,
    input logic signed [31:0] t2, input logic signed [31:0] t3,
    input logic signed [31:0] t4, input logic signed [31:0] t5,
    input logic signed [31:0] t6, input logic signed [31:0] t7);
    logic signed [31:0] v;
    unique case (s)
      kfpu_pkg::V_X0:  v = x0;
      kfpu_pkg::V_X1:  v = x1;
      kfpu_pkg::V_P00: v = p00;
      kfpu_pkg::V_P01: v = p01;
      kfpu_pkg::V_P10: v = p10;
      kfpu_pkg::V_P11: v = p11;
      kfpu_pkg::V_T0:  v = t0;
      kfpu_pkg::V_T1:  v = t1;
      kfpu_pkg::V_T2:  v = t2;
      kfpu_pkg::V_T3:  v = t3;
      kfpu_pkg::V_T4:  v = t4;
      kfpu_pkg::V_T5:  v = t5;
      kfpu_pkg::V_T6:  v = t6;
      kfpu_pkg::V_T7:  v = t7;
      default:         v = '0;
    endcase
    return v;
  endfunction

  // Returns {clipped, value} for the signed 32-bit range.
  function automatic logic [32:0] clip(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] vmax, vmin;
    vmax = $signed(AW'(32'h7fff_ffff));
    vmin = -vmax - $signed(AW'(1));
    if (v > vmax) return {1'b1, 32'h7fff_ffff};
    if (v < vmin) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  logic signed [31:0] a_val, b_val, dst_old;
  logic signed [15:0] q_coef;
  logic signed [63:0] prod_d;
  logic signed [AW-1:0] rnd_c, rnd_sum, sh, term_v, q_ext, r_ext;
  logic [32:0]          inner, res;
  logic signed [31:0]   wr_val;
  logic                 wr_flag, wr_en, eff_hi;
  logic [31:0]          num_mag, den_mag;
  logic [DW-1:0]        dividend;
  logic                 div_done, div_ovf;
  logic [QW-1:0]        div_quo;
  logic signed [31:0]   div_val;
  logic                 div_flag;

  assign a_val = vget(cmd_i.a, x0_q, x1_q, p00_q, p01_q, p10_q, p11_q,
                      t0_q, t1_q, t2_q, t3_q, t4_q, t5_q, t6_q, t7_q);
  assign dst_old = vget(cmd_i.dst, x0_q, x1_q, p00_q, p01_q, p10_q, p11_q,
                        t0_q, t1_q, t2_q, t3_q, t4_q, t5_q, t6_q, t7_q);

  always_comb begin
    unique case (cmd_i.b)
      kfpu_pkg::B_F00: b_val = 32'(signed'(trans_q[63:48]));
      kfpu_pkg::B_F01: b_val = 32'(signed'(trans_q[47:32]));
      kfpu_pkg::B_F10: b_val = 32'(signed'(trans_q[31:16]));
      kfpu_pkg::B_F11: b_val = 32'(signed'(trans_q[15:0]));
      kfpu_pkg::B_H0:  b_val = 32'(signed'(hrow_q[31:16]));
      kfpu_pkg::B_H1:  b_val = 32'(signed'(hrow_q[15:0]));
      kfpu_pkg::B_T4:  b_val = t4_q;
      kfpu_pkg::B_T6:  b_val = t6_q;
      kfpu_pkg::B_T7:  b_val = t7_q;
      default:         b_val = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.qsel)
      2'd0:    q_coef = signed'(pnoise_q[63:48]);
      2'd1:    q_coef = signed'(pnoise_q[47:32]);
      2'd2:    q_coef = signed'(pnoise_q[31:16]);
      default: q_coef = signed'(pnoise_q[15:0]);
    endcase
  end

  assign prod_d  = a_val * b_val;
  assign rnd_c   = cmd_i.frac ? $signed(AW'(1) << (FRAC_BITS - 1)) : $signed(AW'(128));
  assign rnd_sum = acc_q + rnd_c;
  assign sh      = cmd_i.frac ? (rnd_sum >>> FRAC_BITS) : (rnd_sum >>> 8);
  assign q_ext   = AW'(q_coef) <<< WID;
  assign r_ext   = AW'(signed'(rnoise_q)) <<< WID;
  assign inner   = clip(sh);

  always_comb begin
    case (cmd_i.term)
      kfpu_pkg::T_QADD: term_v = sh + q_ext;
      kfpu_pkg::T_RADD: term_v = sh + r_ext;
      kfpu_pkg::T_ZSUB: term_v = AW'(z_q) - AW'(signed'(inner[31:0]));
      kfpu_pkg::T_DADD: term_v = AW'(dst_old) + sh;
      kfpu_pkg::T_DSUB: term_v = AW'(dst_old) - sh;
      default:          term_v = sh;
    endcase
  end

  assign res = clip(term_v);

  // Gain division: magnitudes in, rounding bias folded into the dividend.
  assign num_mag  = a_val[31] ? 32'(-a_val) : 32'(a_val);
  assign den_mag  = t5_q[31] ? 32'(-t5_q) : 32'(t5_q);
  assign dividend = (DW'(num_mag) << FRAC_BITS) + DW'(den_mag >> 1);

  kfpu_div #(
    .DW (DW),
    .QW (QW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (den_mag),
    .done_o     (div_done),
    .ovf_o      (div_ovf),
    .quo_o      (div_quo)
  );

  always_comb begin
    div_flag = 1'b0;
    if (div_neg_q) begin
      if (div_ovf || div_quo > QW'(33'h0_8000_0000)) begin
        div_flag = 1'b1;
        div_val  = 32'h8000_0000;
      end else begin
        div_val = 32'(-div_quo);
      end
    end else begin
      if (div_ovf || div_quo > QW'(33'h0_7fff_ffff)) begin
        div_flag = 1'b1;
        div_val  = 32'h7fff_ffff;
      end else begin
        div_val = div_quo[31:0];
      end
    end
  end

  // With one state element, writes to second-element entries become zero.
  assign eff_hi = cmd_i.hi && (STATE_SIZE < 2);
  assign wr_en  = cmd_i.wb || cmd_i.copy || cmd_i.div_wb;

  always_comb begin
    if (cmd_i.copy) begin
      wr_val  = a_val;
      wr_flag = 1'b0;
    end else if (cmd_i.div_wb) begin
      wr_val  = div_val;
      wr_flag = div_flag;
    end else begin
      wr_val  = signed'(res[31:0]);
      wr_flag = res[32] || (cmd_i.term == kfpu_pkg::T_ZSUB && inner[32]);
    end
    if (eff_hi) begin
      wr_val  = '0;
      wr_flag = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_q  <= kfpu_pkg::TRANS_RESET;
      pnoise_q <= kfpu_pkg::PNOISE_RESET;
      hrow_q   <= kfpu_pkg::HROW_RESET;
      rnoise_q <= kfpu_pkg::RNOISE_RESET;
    end else if (cfg_we_i) begin
      unique case (kfpu_pkg::reg_e'(cfg_index_i))
        kfpu_pkg::REG_TRANS:  trans_q  <= cfg_data_i;
        kfpu_pkg::REG_PNOISE: pnoise_q <= cfg_data_i;
        kfpu_pkg::REG_HROW:   hrow_q   <= cfg_data_i[31:0];
        kfpu_pkg::REG_RNOISE: rnoise_q <= cfg_data_i[15:0];
        default:              trans_q  <= trans_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x0_q  <= '0;
      x1_q  <= '0;
      p00_q <= 32'(1) << FRAC_BITS;
      p01_q <= '0;
      p10_q <= '0;
      p11_q <= (STATE_SIZE > 1) ? (32'(1) << FRAC_BITS) : '0;
      t0_q  <= '0;
      t1_q  <= '0;
      t2_q  <= '0;
      t3_q  <= '0;
      t4_q  <= '0;
      t5_q  <= '0;
      t6_q  <= '0;
      t7_q  <= '0;
      sat_q <= 1'b0;
      mac_q <= 1'b0;
      clr_q <= 1'b0;
      acc_q <= '0;
    end else begin
      mac_q <= cmd_i.mac;
      clr_q <= cmd_i.clr;
      if (mac_q) begin
        acc_q <= (clr_q ? '0 : acc_q) + AW'(prod_q);
      end
      if (cmd_i.load) begin
        sat_q <= 1'b0;
      end else if (wr_en && wr_flag) begin
        sat_q <= 1'b1;
      end
      if (wr_en) begin
        unique case (cmd_i.dst)
          kfpu_pkg::V_X0:  x0_q  <= wr_val;
          kfpu_pkg::V_X1:  x1_q  <= wr_val;
          kfpu_pkg::V_P00: p00_q <= wr_val;
          kfpu_pkg::V_P01: p01_q <= wr_val;
          kfpu_pkg::V_P10: p10_q <= wr_val;
          kfpu_pkg::V_P11: p11_q <= wr_val;
          kfpu_pkg::V_T0:  t0_q  <= wr_val;
          kfpu_pkg::V_T1:  t1_q  <= wr_val;
          kfpu_pkg::V_T2:  t2_q  <= wr_val;
          kfpu_pkg::V_T3:  t3_q  <= wr_val;
          kfpu_pkg::V_T4:  t4_q  <= wr_val;
          kfpu_pkg::V_T5:  t5_q  <= wr_val;
          kfpu_pkg::V_T6:  t6_q  <= wr_val;
          kfpu_pkg::V_T7:  t7_q  <= wr_val;
          default:         t0_q  <= t0_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load) begin
      z_q <= measurement_i;
    end
    if (cmd_i.div_start) begin
      div_neg_q <= a_val[31] ^ t5_q[31];
    end
    if (cmd_i.publish) begin
      est_first_q  <= x0_q;
      est_second_q <= x1_q;
      cov_00_q     <= p00_q;
      cov_01_q     <= p01_q;
      cov_10_q     <= p10_q;
      cov_11_q     <= p11_q;
      sing_out_q   <= cmd_i.sing;
      sat_out_q    <= sat_q;
    end
  end

  assign sts_o.s_zero   = (t5_q == '0);
  assign sts_o.div_done = div_done;

  assign est_first_o  = est_first_q;
  assign est_second_o = est_second_q;
  assign cov_00_o     = cov_00_q;
  assign cov_01_o     = cov_01_q;
  assign cov_10_o     = cov_10_q;
  assign cov_11_o     = cov_11_q;
  assign singular_o   = sing_out_q;
  assign saturated_o  = sat_out_q;

endmodule

>>> rtl/core/kfpu_ctrl.sv
module kfpu_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           mode_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  kfpu_pkg::sts_t sts_i,
  output kfpu_pkg::cmd_t cmd_o
);

  kfpu_pkg::state_e         state_q, state_d;
  logic [kfpu_pkg::PC_W-1:0] pc_q, pc_d;
  logic                     sing_q, sing_d, out_valid_q, out_valid_d;
  kfpu_pkg::ins_t           ins;

  assign ins = kfpu_pkg::prog(pc_q);

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    sing_d      = sing_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o           = '0;
    cmd_o.a         = ins.a0;
    cmd_o.b         = ins.b0;
    cmd_o.frac      = ins.frac;
    cmd_o.term      = ins.term;
    cmd_o.qsel      = ins.qsel;
    cmd_o.dst       = ins.dst;
    cmd_o.hi        = ins.hi;
    unique case (state_q)
      kfpu_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pc_d       = mode_i ? kfpu_pkg::UPD_BASE : kfpu_pkg::PRED_BASE;
          sing_d     = 1'b0;
          state_d    = kfpu_pkg::S_EXEC;
        end
      end
      kfpu_pkg::S_EXEC: begin
        unique case (ins.kind)
          kfpu_pkg::I_DOT: begin
            cmd_o.mac = 1'b1;
            cmd_o.clr = 1'b1;
            state_d   = ins.two ? kfpu_pkg::S_MAC1 : kfpu_pkg::S_WAIT;
          end
          kfpu_pkg::I_COPY: begin
            cmd_o.copy = 1'b1;
            pc_d       = pc_q + 1'b1;
          end
          kfpu_pkg::I_CHK: begin
            if (sts_i.s_zero) begin
              sing_d  = 1'b1;
              state_d = kfpu_pkg::S_FIN;
            end else begin
              pc_d = pc_q + 1'b1;
            end
          end
          kfpu_pkg::I_DIV: begin
            cmd_o.div_start = 1'b1;
            state_d         = kfpu_pkg::S_DIVW;
          end
          default: state_d = kfpu_pkg::S_FIN;
        endcase
      end
      kfpu_pkg::S_MAC1: begin
        cmd_o.mac = 1'b1;
        cmd_o.a   = ins.a1;
        cmd_o.b   = ins.b1;
        state_d   = kfpu_pkg::S_WAIT;
      end
      // The last product still passes from the product register into the accumulator.
      kfpu_pkg::S_WAIT: state_d = kfpu_pkg::S_WB;
      kfpu_pkg::S_WB: begin
        cmd_o.wb = 1'b1;
        pc_d     = pc_q + 1'b1;
        state_d  = kfpu_pkg::S_EXEC;
      end
      kfpu_pkg::S_DIVW: begin
        if (sts_i.div_done) begin
          cmd_o.div_wb = 1'b1;
          pc_d         = pc_q + 1'b1;
          state_d      = kfpu_pkg::S_EXEC;
        end
      end
      kfpu_pkg::S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          cmd_o.sing    = sing_q;
          out_valid_d   = 1'b1;
          state_d       = kfpu_pkg::S_IDLE;
        end
      end
      default: state_d = kfpu_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kfpu_pkg::S_IDLE;
      pc_q        <= '0;
      sing_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      sing_q      <= sing_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == kfpu_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/kalman_filter_predict_update_unit.sv
// Two-state linear Kalman filter, one scalar measurement, fixed point.
// Input channel (in_valid_i/in_ready_o) carries one word: mode_i selects a
// predict step (0) or a measurement update (1) with measurement_i. Each word
// yields one result word on the output channel (out_valid_o/out_ready_i):
// the new estimate, all four covariance entries and the two flags.
// A predict runs twenty products through the single shared multiplier and
// its accumulator. In an update, two gain divisions in the radix-2 divider,
// one quotient bit per cycle, dominate; a singular update ends at the
// variance check. One word is in flight at a time; the next word is
// accepted as soon as the previous result sits in the output register.
// If the receiver stalls, the result holds in the output register; a
// following word is processed but waits for that register to drain.
// Reset clears the estimate, sets the covariance to identity and loads the
// default coefficients. Configuration writes take effect at once and are
// meant for idle periods only.
module kalman_filter_predict_update_unit #(
  parameter int STATE_SIZE = kfpu_pkg::STATE_SIZE_DEF,
  parameter int FRAC_BITS  = kfpu_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kfpu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kfpu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic signed [31:0]              measurement_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [31:0]              est_first_o,
  output logic signed [31:0]              est_second_o,
  output logic signed [31:0]              cov_00_o,
  output logic signed [31:0]              cov_01_o,
  output logic signed [31:0]              cov_10_o,
  output logic signed [31:0]              cov_11_o,
  output logic                            singular_o,
  output logic                            saturated_o
);

  kfpu_pkg::cmd_t cmd;
  kfpu_pkg::sts_t sts;

  kfpu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kfpu_datapath #(
    .STATE_SIZE (STATE_SIZE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .measurement_i (measurement_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .est_first_o   (est_first_o),
    .est_second_o  (est_second_o),
    .cov_00_o      (cov_00_o),
    .cov_01_o      (cov_01_o),
    .cov_10_o      (cov_10_o),
    .cov_11_o      (cov_11_o),
    .singular_o    (singular_o),
    .saturated_o   (saturated_o)
  );

endmodule

>>> rtl/core/kfpu_checker.sv
module kfpu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] est_first_o,
  input logic [31:0] cov_00_o
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(est_first_o) && $stable(cov_00_o))
    else $error("output word changed while stalled");

  // Accepting a word makes the block busy on the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // A new result appears exactly when the block returns to idle.
  a_publish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result published while still busy");

endmodule

bind kalman_filter_predict_update_unit kfpu_checker u_kfpu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .est_first_o (est_first_o),
  .cov_00_o    (cov_00_o)
);
